[src/bw_pkg.sv]
package bw_pkg;

   // store geometry
   localparam int STORE_BYTES = 4096;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int STORE_BITS  = STORE_BYTES * 8;
   localparam int POS_W       = $clog2(STORE_BITS + 1);
   localparam int BYTE_IDX_W  = POS_W - 3;

   // literal limits and bit window used to merge a literal into bytes
   localparam int VALUE_W     = 31;
   localparam int LEN_W       = 5;
   localparam int WIN_W       = 40;
   localparam int SHIFT_W     = $clog2(WIN_W + 1);
   localparam int WIN_BYTES_W = 3;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes
   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_LENGTH   = 3'd1;
   localparam logic [2:0] STATUS_TOO_WIDE     = 3'd2;
   localparam logic [2:0] STATUS_NOT_COMPLETE = 3'd3;
   localparam logic [2:0] STATUS_FULL         = 3'd4;

   // one port pair into the byte memory
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

[src/bw_ifs.sv]
interface bw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [30:0] value;
   logic [4:0]  length;
   logic [11:0] byte_index;

   modport source (output valid, op, value, length, byte_index, input ready);
   modport sink (input valid, op, value, length, byte_index, output ready);
endinterface

interface bw_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [15:0] position;
   logic [2:0]  status;

   modport source (output valid, read_data, position, status, input ready);
   modport sink (input valid, read_data, position, status, output ready);
endinterface

[src/bw_store.sv]
module bw_store
   import bw_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata
);

   logic [7:0] store_mem [STORE_BYTES];
   logic [7:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= store_mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/bw_ctrl.sv]
module bw_ctrl
   import bw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   bw_req_if.sink        req,
   bw_rsp_if.source      rsp,
   output mem_req_type   mem_req,
   input  logic [7:0]    mem_rdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FETCH  = 4'b0010,
      ST_WRITE  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              op_ff, op_in;
   logic [VALUE_W-1:0]      val_ff, val_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [WIN_W-1:0]        win_ff, win_in;
   logic [ADDR_W-1:0]       waddr_ff, waddr_in;
   logic [WIN_BYTES_W-1:0]  cnt_ff, cnt_in;
   logic [7:0]              res_data_ff, res_data_in;
   logic [2:0]              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    out_free;
   logic [POS_W:0]          pos_sum;
   logic                    too_wide;
   logic                    store_full;
   logic                    index_ok;
   logic [2:0]              bit_off;
   logic [7:0]              keep_byte;
   logic [SHIFT_W-1:0]      lit_shift;
   logic [WIN_W-1:0]        lit_win;
   logic [5:0]              span;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // checks done on the incoming transaction
   assign pos_sum    = {1'b0, pos_ff} + (POS_W+1)'(req.length);
   assign too_wide   = (req.value >> req.length) != '0;
   assign store_full = pos_sum > (POS_W+1)'(STORE_BITS);
   assign index_ok   = {1'b0, req.byte_index} < pos_ff[POS_W-1:3];

   // merge the partial byte with the literal in a five-byte window
   assign bit_off   = pos_ff[2:0];
   assign keep_byte = mem_rdata & ~(8'hFF >> bit_off);
   assign lit_shift = SHIFT_W'(WIN_W) - SHIFT_W'(bit_off) - SHIFT_W'(len_ff);
   assign lit_win   = WIN_W'(val_ff) << lit_shift;
   assign span      = 6'(bit_off) + 6'(len_ff) + 6'd7;

   // memory access: read on accept (the target byte or the partial byte), write in ST_WRITE
   always_comb begin
      mem_req.raddr = (req.op == OP_READ) ? req.byte_index : pos_ff[ADDR_W+2:3];
      mem_req.we    = (state_ff == ST_WRITE);
      mem_req.waddr = waddr_ff;
      mem_req.wdata = win_ff[WIN_W-1 -: 8];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      win_in        = win_ff;
      waddr_in      = waddr_ff;
      cnt_in        = cnt_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req.op;
               val_in        = req.value;
               len_in        = req.length;
               res_data_in   = 8'd0;
               res_status_in = STATUS_OK;
               state_in      = ST_RESULT;
               case (req.op)
                  OP_WRITE: begin
                     if (req.length == '0) begin
                        res_status_in = STATUS_BAD_LENGTH;
                     end else if (too_wide) begin
                        res_status_in = STATUS_TOO_WIDE;
                     end else if (store_full) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  OP_READ: begin
                     if (index_ok) begin
                        state_in = ST_FETCH;
                     end else begin
                        res_status_in = STATUS_NOT_COMPLETE;
                     end
                  end
                  OP_CLEAR: begin
                     pos_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (op_ff == OP_READ) begin
               res_data_in = mem_rdata;
               state_in    = ST_RESULT;
            end else begin
               win_in   = {keep_byte, 32'd0} | lit_win;
               cnt_in   = span[5:3];
               waddr_in = pos_ff[ADDR_W+2:3];
               pos_in   = pos_ff + POS_W'(len_ff);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            win_in   = win_ff << 8;
            waddr_in = waddr_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == WIN_BYTES_W'(1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_pos_in    = pos_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      len_ff        <= len_in;
      win_ff        <= win_in;
      waddr_ff      <= waddr_in;
      cnt_ff        <= cnt_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
   assign rsp.position  = rsp_pos_ff;
   assign rsp.status    = rsp_status_ff;

endmodule

[src/msb_first_bit_writer_top.sv]
// MSB-first bitstream writer over a 4096-byte store. Each request transaction is a write
// (append a 1 to 31 bit literal, highest bit first), a read of a completed byte, or a
// clear of the bit position; each yields one response transaction with the byte read,
// the bit position afterwards and a status. Requests are handled one at a time through
// a byte memory with one write port and one registered read port: a write first fetches
// the partially filled byte, then writes the n (1 to 5) bytes the literal touches, one per
// cycle on the memory write port; a successful read fetches the target byte; a clear, a
// failed read, a rejected write or an unknown op goes straight to the response.
// The response sits in an output register, so the next request is taken while the
// previous response still waits; a request whose response finds that register still
// occupied holds until it drains. No clearing pass is needed after reset.
module msb_first_bit_writer_top
   import bw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bw_req_if.sink    req_chan,
   bw_rsp_if.source  rsp_chan
);

   mem_req_type mem_req;
   logic [7:0]  mem_rdata;

   bw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   bw_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   // read data is only returned by a successful read
   a_data_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != STATUS_OK |-> rsp_chan.read_data == 8'd0)
      else $error("nonzero read data on failed transaction");

   // position never passes the end of the store
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.position <= POS_W'(STORE_BITS))
      else $error("position beyond store");

   // no memory write while a new request can be taken
   a_no_write_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !mem_req.we)
      else $error("memory write while idle");

   // a response is only loaded once the previous one is gone
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("pending response dropped");

endmodule
